// ===== rtl/core/kmt_pkg.sv =====
// Shared types and constants for the killer move table and list reorder block.
// Used by kmt_killer_table and killer_move_table_and_reorder; no dependencies.
package kmt_pkg;

  localparam int MAX_PLY_DEF   = 64;
  localparam int LIST_SIZE_DEF = 64;
  localparam int MOVE_W        = 32;
  localparam int CNT_W         = 7;   // list length and list walk counters
  localparam int DEPTH_CMP_W   = 9;   // room for a depth bound up to 511

  // Request codes carried in req_type
  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_SAVE    = 2'd1;
  localparam logic [1:0] REQ_REORDER = 2'd2;
  localparam logic [1:0] REQ_CLEAR   = 2'd3;

  typedef struct packed {
    logic [1:0]               req_type;
    logic                     first;
    logic [MOVE_W-1:0]        move_code;
    logic signed [MOVE_W-1:0] move_score;
    logic [5:0]               ply_depth;
    logic [5:0]               position;
  } req_t;

  typedef struct packed {
    logic [MOVE_W-1:0]        out_move;
    logic signed [MOVE_W-1:0] out_score;
    logic                     last;
  } rsp_t;

  typedef struct packed {
    logic [MOVE_W-1:0]        move;
    logic signed [MOVE_W-1:0] score;
  } entry_t;

  typedef struct packed {
    logic [MOVE_W-1:0] first;
    logic [MOVE_W-1:0] second;
  } kill_pair_t;

  typedef struct packed {
    logic wr_en;
    logic clear;
  } kt_ctrl_t;

endpackage

// ===== rtl/core/kmt_killer_table.sv =====
// Killer pair storage: one memory row per depth plus a valid bit per row.
// An invalid row reads as an empty pair; clear drops every valid bit at once.
// Depends on kmt_pkg.
module kmt_killer_table #(
  parameter int MAX_PLY = kmt_pkg::MAX_PLY_DEF,
  localparam int KW     = (MAX_PLY > 1) ? $clog2(MAX_PLY) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  kmt_pkg::kt_ctrl_t   ctrl,
  input  logic [KW-1:0]       rd_addr,
  input  logic [KW-1:0]       wr_addr,
  input  kmt_pkg::kill_pair_t wr_data,
  output kmt_pkg::kill_pair_t rd_data
);

  kmt_pkg::kill_pair_t kmem [MAX_PLY];
  logic [MAX_PLY-1:0]  valid;
  kmt_pkg::kill_pair_t rd_q;
  logic                rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctrl.clear) begin
      valid <= '0;
    end else if (ctrl.wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      kmem[wr_addr] <= wr_data;
    end
    rd_q     <= kmem[rd_addr];
    rd_valid <= valid[rd_addr];
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule

// ===== rtl/core/killer_move_table_and_reorder.sv =====
// Killer move table with move list reorder. Load and clear leave busy low. Save holds busy
// for one cycle. Reorder reads the killer pair of the depth; for each killer it scans the list
// from the killer's start slot and, on a find, shifts the entries between one slot back and
// drops the move into the start slot; then it streams the list. Results follow one a cycle,
// the last as busy drops. Scan and shift share one list memory read port. Reset empties all
// killers and the list; list storage is not cleared. Results are never stalled.
module killer_move_table_and_reorder #(
  parameter int MAX_PLY   = kmt_pkg::MAX_PLY_DEF,
  parameter int LIST_SIZE = kmt_pkg::LIST_SIZE_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  kmt_pkg::req_t request,
  output logic          busy,
  output kmt_pkg::rsp_t result,
  output logic          result_valid
);

  localparam int CNT_W = kmt_pkg::CNT_W;
  localparam int LW    = $clog2(LIST_SIZE);
  localparam int KW    = (MAX_PLY > 1) ? $clog2(MAX_PLY) : 1;
  localparam int DXW   = (KW > 6) ? KW : 6;
  localparam logic [CNT_W-1:0] LIST_MAX = CNT_W'(LIST_SIZE);
  localparam logic [kmt_pkg::DEPTH_CMP_W-1:0] PLY_MAX = kmt_pkg::DEPTH_CMP_W'(MAX_PLY);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_SAVE     = 9'b000000010,
    S_KILL     = 9'b000000100,
    S_PULL     = 9'b000001000,
    S_SRCH_RD  = 9'b000010000,
    S_SRCH_CMP = 9'b000100000,
    S_SH_RD    = 9'b001000000,
    S_SH_WR    = 9'b010000000,
    S_EMIT     = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0]          len;
  logic [CNT_W-1:0]          pos_q;
  logic [CNT_W-1:0]          from;
  logic [CNT_W-1:0]          idx;
  logic [KW-1:0]             depth_idx_q;
  logic                      depth_ok_q;
  logic [kmt_pkg::MOVE_W-1:0] tgt;
  logic [kmt_pkg::MOVE_W-1:0] k2_q;
  logic signed [kmt_pkg::MOVE_W-1:0] found_score;
  logic                      phase;
  logic                      emit_v;
  logic                      emit_last;

  logic                      accept;
  logic [DXW-1:0]            depth_wide;
  logic [KW-1:0]             depth_idx_in;
  logic                      depth_ok_in;
  logic [CNT_W-1:0]          pos_in;
  logic [CNT_W-1:0]          idx_m1;
  logic [CNT_W-1:0]          idx_p1;
  logic                      pull_done;
  logic                      hit;
  logic                      save_hit;

  kmt_pkg::entry_t           lmem [LIST_SIZE];
  kmt_pkg::entry_t           rd_q;
  logic [LW-1:0]             rd_addr;
  logic                      wr_en;
  logic [LW-1:0]             wr_addr;
  kmt_pkg::entry_t           wr_data;

  kmt_pkg::kt_ctrl_t         kt_ctrl;
  logic [KW-1:0]             kt_raddr;
  kmt_pkg::kill_pair_t       kt_wdata;
  kmt_pkg::kill_pair_t       kpair;

  assign accept       = start && (state == S_IDLE);
  assign busy         = (state != S_IDLE);
  assign depth_wide   = DXW'(request.ply_depth);
  assign depth_idx_in = depth_wide[KW-1:0];
  assign depth_ok_in  = ({3'b000, request.ply_depth} < PLY_MAX);
  assign pos_in       = CNT_W'(request.position);
  assign idx_m1       = idx - CNT_W'(1);
  assign idx_p1       = idx + CNT_W'(1);
  assign hit          = (rd_q.move == tgt);
  assign save_hit     = depth_ok_q && (pos_q < len) && (kpair.first != rd_q.move);

  // A pull ends when there is no killer, the start is at or past the end, the scan
  // runs off the end, or the found entry has landed at its start slot.
  always_comb begin
    pull_done = 1'b0;
    unique case (state)
      S_PULL:     pull_done = (tgt == '0) || (from >= len);
      S_SRCH_CMP: pull_done = !hit && (idx_p1 >= len);
      S_SH_RD:    pull_done = (idx == from);
      default:    pull_done = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && request.req_type == kmt_pkg::REQ_SAVE) begin
          state_next = S_SAVE;
        end else if (accept && request.req_type == kmt_pkg::REQ_REORDER) begin
          state_next = S_KILL;
        end
      end
      S_SAVE:     state_next = S_IDLE;
      S_KILL:     state_next = S_PULL;
      S_PULL:     state_next = S_SRCH_RD;
      S_SRCH_RD:  state_next = S_SRCH_CMP;
      S_SRCH_CMP: state_next = hit ? S_SH_RD : S_SRCH_RD;
      S_SH_RD:    state_next = S_SH_WR;
      S_SH_WR:    state_next = S_SH_RD;
      S_EMIT:     state_next = (idx_p1 == len) ? S_IDLE : S_EMIT;
      default:    state_next = S_IDLE;
    endcase
    if (pull_done) begin
      if (!phase) begin
        state_next = S_PULL;
      end else begin
        state_next = (len == '0) ? S_IDLE : S_EMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      len    <= '0;
      emit_v <= 1'b0;
    end else begin
      state  <= state_next;
      emit_v <= (state == S_EMIT);
      if (accept && request.req_type == kmt_pkg::REQ_LOAD) begin
        if (request.first) begin
          len <= CNT_W'(1);
        end else if (len < LIST_MAX) begin
          len <= len + CNT_W'(1);
        end
      end
    end
  end

  // Datapath registers of the sequencer
  always_ff @(posedge clk) begin
    emit_last <= (idx_p1 == len);
    if (pull_done) begin
      if (!phase) begin
        phase <= 1'b1;
        tgt   <= k2_q;
        from  <= pos_q + CNT_W'(1);
      end else begin
        idx <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          depth_idx_q <= depth_idx_in;
          depth_ok_q  <= depth_ok_in;
          pos_q       <= pos_in;
        end
        S_KILL: begin
          tgt   <= depth_ok_q ? kpair.first : '0;
          k2_q  <= depth_ok_q ? kpair.second : '0;
          from  <= pos_q;
          phase <= 1'b0;
        end
        S_PULL:     idx <= from;
        S_SRCH_CMP: begin
          if (hit) begin
            found_score <= rd_q.score;
          end else begin
            idx <= idx_p1;
          end
        end
        S_SH_WR:    idx <= idx_m1;
        S_EMIT:     idx <= idx_p1;
        default: ;
      endcase
    end
  end

  // List memory port selection
  always_comb begin
    unique case (state)
      S_IDLE:  rd_addr = pos_in[LW-1:0];
      S_SH_RD: rd_addr = idx_m1[LW-1:0];
      default: rd_addr = idx[LW-1:0];
    endcase
    wr_en   = 1'b0;
    wr_addr = idx[LW-1:0];
    wr_data = rd_q;
    unique case (state)
      S_IDLE: begin
        if (accept && request.req_type == kmt_pkg::REQ_LOAD) begin
          wr_en   = request.first || (len < LIST_MAX);
          wr_addr = request.first ? '0 : len[LW-1:0];
          wr_data = '{move: request.move_code, score: request.move_score};
        end
      end
      S_SH_RD: begin
        // Drop the found move into its start slot once the gap reaches it
        wr_en   = (idx == from);
        wr_data = '{move: tgt, score: found_score};
      end
      S_SH_WR: wr_en = 1'b1;
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lmem[wr_addr] <= wr_data;
    end
    rd_q <= lmem[rd_addr];
  end

  assign kt_ctrl.wr_en = (state == S_SAVE) && save_hit;
  assign kt_ctrl.clear = accept && (request.req_type == kmt_pkg::REQ_CLEAR);
  assign kt_raddr      = (state == S_IDLE) ? depth_idx_in : depth_idx_q;
  assign kt_wdata      = '{first: rd_q.move, second: kpair.first};

  kmt_killer_table #(
    .MAX_PLY (MAX_PLY)
  ) u_killers (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (kt_ctrl),
    .rd_addr (kt_raddr),
    .wr_addr (depth_idx_q),
    .wr_data (kt_wdata),
    .rd_data (kpair)
  );

  assign result_valid     = emit_v;
  assign result.out_move  = rd_q.move;
  assign result.out_score = rd_q.score;
  assign result.last      = emit_last;

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LIST_MAX) else $error("list length beyond capacity");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |=> !result_valid)
    else $error("transaction follows the last entry of a list");

  a_from_emit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == S_EMIT)) else $error("result outside list streaming");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRCH_RD) |-> (idx < len)) else $error("scan past list end");

  a_shift_gap: assert property (@(posedge clk) disable iff (rst)
    (state == S_SH_WR) |-> (idx > from)) else $error("shift below start slot");

endmodule
